/* sv/gbl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_pkg: shared definitions for the RGB 3x3 Gaussian blur
// Frame limits, counter widths, register indexes, channel lanes, the kernel
// weights and the structs that pass between the blur modules.
// ----------------------------------------------------------------------------
package gbl_pkg;

  // Frame limits and the counter widths that follow from them.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);       // column index, 0..MAX_WIDTH-1
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);   // a width value, up to MAX_WIDTH
  localparam int HGT_W      = $clog2(MAX_HEIGHT + 1);  // a height value, up to MAX_HEIGHT
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);  // row counter, up to height + 1

  // Configuration port.
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 12'd2048;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd4096;

  // Color lanes.
  localparam int NUM_CH   = 3;
  localparam int CH_RED   = 2;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 0;

  // A weighted sum of nine 8-bit samples with total weight 16 fits 12 bits.
  localparam int SUM_W = 12;

  // Output queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Sides of the 3x3 neighborhood that fall outside the frame.
  typedef struct packed {
    logic top_out;
    logic bot_out;
    logic left_out;
    logic right_out;
  } flags_t;

  // One line buffer entry: the pixel of the row above and of two rows above.
  typedef struct packed {
    rgb_t above;
    rgb_t two_above;
  } lb_entry_t;

  // Decisions made when an item is accepted, carried into the line buffer.
  typedef struct packed {
    logic             shift;
    logic             emit;
    logic             edge_sel;
    logic [COL_W-1:0] idx;
    rgb_t             sample;
    flags_t           flags;
    logic             frame_end;
  } lb_req_t;

  // One color of the neighborhood, [row][column], column 0 on the left.
  typedef logic [2:0][2:0][7:0] chan_win_t;

  typedef struct packed {
    flags_t                       flags;
    logic                         frame_end;
    chan_win_t [NUM_CH-1:0]       win;
  } tap_t;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } out_beat_t;

  // Kernel weights 1 2 1 / 2 4 2 / 1 2 1.
  function automatic logic [2:0] gauss_wt(input int row, input int col);
    logic [2:0] wt;
    if (row == 1 && col == 1) begin
      wt = 3'd4;
    end else if (row == 1 || col == 1) begin
      wt = 3'd2;
    end else begin
      wt = 3'd1;
    end
    return wt;
  endfunction

endpackage

/* sv/gbl_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_ifs: channel interfaces of the Gaussian blur
// Pixel input, blurred pixel output and register write channels, each with
// valid, ready and its payload.
// ----------------------------------------------------------------------------
interface gbl_pix_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, output op, output in_red, output in_green,
                  output in_blue, input ready);
  modport sink   (input valid, input op, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface gbl_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       frame_end;

  modport source (output valid, output out_red, output out_green, output out_blue,
                  output frame_end, input ready);
  modport sink   (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

interface gbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/gbl_line_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_line_buf: line buffers and 3x3 window
// Holds the two previous rows in one memory, shifts the window one column per
// pixel and selects the neighborhood taps for the blur lanes.
// ----------------------------------------------------------------------------
module gbl_line_buf
  import gbl_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  lb_req_t req,
  output logic    s1_valid,
  output logic    tap_valid,
  output tap_t    tap
);

  lb_entry_t mem [MAX_WIDTH];
  lb_entry_t rd_q;
  lb_req_t   s1;
  rgb_t      win [3][3];
  rgb_t      new_col [3];
  rgb_t      taps [3][3];

  // Read at accept time; the entry is rewritten in the next cycle.
  always_ff @(posedge clk) begin
    if (req_valid && req.shift) begin
      rd_q <= mem[req.idx];
    end
    if (s1_valid && s1.shift) begin
      mem[s1.idx] <= '{above: s1.sample, two_above: rd_q.above};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      tap_valid <= 1'b0;
    end else begin
      s1_valid  <= req_valid;
      tap_valid <= s1_valid && s1.emit;
    end
  end

  always_ff @(posedge clk) begin
    s1 <= req;
  end

  always_comb begin
    new_col[0] = rd_q.two_above;
    new_col[1] = rd_q.above;
    new_col[2] = s1.sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else if (s1_valid && s1.shift) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
        win[i][2] <= new_col[i];
      end
    end
  end

  // The right-edge pixel of a row uses the window before this shift, with
  // the last column doubled; every other pixel uses the shifted window.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      taps[i][0] = win[i][1];
      taps[i][1] = win[i][2];
      taps[i][2] = s1.edge_sel ? win[i][2] : new_col[i];
    end
  end

  always_ff @(posedge clk) begin
    tap.flags     <= s1.flags;
    tap.frame_end <= s1.frame_end;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        tap.win[CH_RED][i][j]   <= taps[i][j].red;
        tap.win[CH_GREEN][i][j] <= taps[i][j].green;
        tap.win[CH_BLUE][i][j]  <= taps[i][j].blue;
      end
    end
  end

endmodule

/* sv/gbl_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_lane: blur of one color channel
// Replaces outside neighbors by the center sample, forms the weighted sum
// and registers it divided by 16.
// ----------------------------------------------------------------------------
module gbl_lane
  import gbl_pkg::*;
(
  input  logic       clk,
  input  chan_win_t  win,
  input  flags_t     flags,
  output logic [7:0] result
);

  logic [SUM_W-1:0] acc;

  always_comb begin
    logic [7:0] centre;
    logic [7:0] px;
    logic       outside;
    centre = win[1][1];
    acc    = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        outside = (i == 0 && flags.top_out) || (i == 2 && flags.bot_out) ||
                  (j == 0 && flags.left_out) || (j == 2 && flags.right_out);
        px  = outside ? centre : win[i][j];
        acc = acc + SUM_W'(gauss_wt(i, j)) * SUM_W'(px);
      end
    end
  end

  always_ff @(posedge clk) begin
    result <= acc[SUM_W-1:4];
  end

endmodule

/* sv/gbl_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbl_merge: lane merge and output queue
// Joins the three lane results and the frame end flag into one beat and
// queues it for the output channel.
// ----------------------------------------------------------------------------
module gbl_merge
  import gbl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  logic [NUM_CH-1:0][7:0]    chan_res,
  input  logic                      frame_end,
  gbl_pix_out_if.source             pix_out,
  output logic [FIFO_CNT_W-1:0]     fifo_count
);

  out_beat_t                 queue [FIFO_DEPTH];
  out_beat_t                 beat_in;
  logic [FIFO_PTR_W-1:0]     wr_ptr;
  logic [FIFO_PTR_W-1:0]     rd_ptr;
  logic                      pop;

  assign beat_in.px.red    = chan_res[CH_RED];
  assign beat_in.px.green  = chan_res[CH_GREEN];
  assign beat_in.px.blue   = chan_res[CH_BLUE];
  assign beat_in.frame_end = frame_end;

  assign pop = pix_out.valid && pix_out.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= beat_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fifo_count <= fifo_count + FIFO_CNT_W'(1);
        2'b01:   fifo_count <= fifo_count - FIFO_CNT_W'(1);
        default: fifo_count <= fifo_count;
      endcase
    end
  end

  assign pix_out.valid     = fifo_count != '0;
  assign pix_out.out_red   = queue[rd_ptr].px.red;
  assign pix_out.out_green = queue[rd_ptr].px.green;
  assign pix_out.out_blue  = queue[rd_ptr].px.blue;
  assign pix_out.frame_end = queue[rd_ptr].frame_end;

endmodule

/* sv/rgb_gaussian_blur_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_gaussian_blur_3x3: streaming 3x3 Gaussian blur of an RGB frame
// Pixels enter in raster order on pix_in and leave blurred on pix_out.
// ----------------------------------------------------------------------------
// Usage. Each pix_in beat with op = 0 carries one pixel of the frame. The
// blurred pixel k leaves on pix_out after pixel k + width + 1 has entered, so
// width + 1 drain beats (op = 1) after the last pixel flush the frame; the
// beat for the last pixel has frame_end set, and the next beat starts a new
// frame. A drain beat inside the frame is accepted and dropped.
// Registers image_width (index 0) and image_height (index 1) are written on
// cfg by the user only while idle (the block does not enforce it); a write
// restarts the frame. Values outside 2..2048 and 2..4096 are clamped.
// Throughput is one beat per cycle while pix_in.ready is high: the line
// buffer memory is read when a beat is accepted and rewritten in the next
// cycle at the same address, so every beat needs one read and one write
// port slot. A result passes the line buffer read, tap select, lane sum
// and queue registers before it appears on pix_out.
// Reset clears the counters, the window and the queue; the line buffers need
// no clearing pass. When the receiver stalls, results wait in an 8-entry
// queue and pix_in keeps accepting until queued plus in-flight beats would
// fill it.
// ----------------------------------------------------------------------------
module rgb_gaussian_blur_3x3
  import gbl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  gbl_pix_in_if.sink    pix_in,
  gbl_pix_out_if.source pix_out,
  gbl_cfg_if.sink       cfg
);

  // Register file and frame position.
  logic [CFG_WIDTH_W-1:0]  cfg_width;
  logic [CFG_HEIGHT_W-1:0] cfg_height;
  logic [WID_W-1:0]        eff_w;
  logic [HGT_W-1:0]        eff_h;
  logic [COL_W-1:0]        col_cnt;
  logic [ROW_W-1:0]        row_cnt;

  logic                    cfg_hit;
  logic                    in_beat;
  logic                    draining;
  logic                    item_go;
  logic                    at_col0;
  logic                    emit_edge;
  logic                    emit_mid;
  logic                    do_shift;
  logic [ROW_W-1:0]        orow;
  logic [WID_W-1:0]        ocol;
  logic                    orow_is_last;
  logic                    frame_end_hit;
  logic [WID_W-1:0]        col_inc;
  logic                    wrap;
  lb_req_t                 req;

  // Pipeline status.
  logic                    s1_valid;
  logic                    tap_valid;
  tap_t                    tap;
  logic                    s3_valid;
  logic                    s3_frame_end;
  logic [NUM_CH-1:0][7:0]  chan_res;
  logic [FIFO_CNT_W-1:0]   fifo_count;
  logic [FIFO_CNT_W:0]     pending;

  assign cfg.ready = 1'b1;
  assign cfg_hit   = cfg.valid && cfg.ready &&
                     (cfg.index == REG_IMAGE_WIDTH || cfg.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == REG_IMAGE_WIDTH) begin
        cfg_width <= cfg.data[CFG_WIDTH_W-1:0];
      end
      if (cfg.index == REG_IMAGE_HEIGHT) begin
        cfg_height <= cfg.data[CFG_HEIGHT_W-1:0];
      end
    end
  end

  // The frame size in use is the register clamped to the supported range.
  always_comb begin
    if (cfg_width < CFG_WIDTH_W'(2)) begin
      eff_w = WID_W'(2);
    end else if (32'(cfg_width) > 32'(MAX_WIDTH)) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg_width);
    end
    if (cfg_height < CFG_HEIGHT_W'(2)) begin
      eff_h = HGT_W'(2);
    end else if (32'(cfg_height) > 32'(MAX_HEIGHT)) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(cfg_height);
    end
  end

  // Accept while the queue has room for everything still in flight.
  assign pending = {1'b0, fifo_count} + {{FIFO_CNT_W{1'b0}}, s1_valid} +
                   {{FIFO_CNT_W{1'b0}}, tap_valid} + {{FIFO_CNT_W{1'b0}}, s3_valid};
  assign pix_in.ready = pending < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_beat      = pix_in.valid && pix_in.ready;

  // Once all rows are in, every beat counts as a drain beat. A drain beat
  // while rows are still coming in changes nothing.
  assign draining = row_cnt >= ROW_W'(eff_h);
  assign item_go  = in_beat && (draining || !pix_in.op);

  // A beat at column zero finishes the right-edge pixel of the row two above;
  // any other beat within the frame finishes the pixel up and to the left.
  assign at_col0   = col_cnt == '0;
  assign emit_edge = at_col0 && row_cnt >= ROW_W'(2);
  assign do_shift  = row_cnt <= ROW_W'(eff_h);
  assign emit_mid  = do_shift && !at_col0 && row_cnt != '0;
  assign orow      = emit_edge ? row_cnt - ROW_W'(2) : row_cnt - ROW_W'(1);
  assign ocol      = emit_edge ? eff_w - WID_W'(1) : WID_W'(col_cnt) - WID_W'(1);
  assign orow_is_last  = orow == ROW_W'(eff_h) - ROW_W'(1);
  assign frame_end_hit = (emit_edge || emit_mid) && orow_is_last &&
                         ocol == eff_w - WID_W'(1);
  assign col_inc   = WID_W'(col_cnt) + WID_W'(1);
  assign wrap      = col_inc >= eff_w;

  always_comb begin
    req.shift           = do_shift;
    req.emit            = emit_edge || emit_mid;
    req.edge_sel        = emit_edge;
    req.idx             = col_cnt;
    req.sample          = draining ? '0 :
                          rgb_t'{red: pix_in.in_red, green: pix_in.in_green,
                                 blue: pix_in.in_blue};
    req.flags.top_out   = orow == '0;
    req.flags.bot_out   = orow_is_last;
    req.flags.left_out  = emit_mid && col_cnt == COL_W'(1);
    req.flags.right_out = emit_edge;
    req.frame_end       = frame_end_hit;
  end

  // A register write restarts the frame; the frame's last pixel does too.
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (item_go) begin
      if (frame_end_hit) begin
        col_cnt <= '0;
        row_cnt <= '0;
      end else if (wrap) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + ROW_W'(1);
      end else begin
        col_cnt <= col_inc[COL_W-1:0];
      end
    end
  end

  gbl_line_buf u_line_buf (
    .clk       (clk),
    .rst       (rst),
    .req_valid (item_go),
    .req       (req),
    .s1_valid  (s1_valid),
    .tap_valid (tap_valid),
    .tap       (tap)
  );

  // One lane for each color, all fed from the same window.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    gbl_lane u_lane (
      .clk    (clk),
      .win    (tap.win[ch]),
      .flags  (tap.flags),
      .result (chan_res[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= tap_valid;
    end
  end

  always_ff @(posedge clk) begin
    s3_frame_end <= tap.frame_end;
  end

  gbl_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .push       (s3_valid),
    .chan_res   (chan_res),
    .frame_end  (s3_frame_end),
    .pix_out    (pix_out),
    .fifo_count (fifo_count)
  );

  // The credit check must keep the queue from ever overflowing.
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= (FIFO_CNT_W + 1)'(FIFO_DEPTH))
    else $error("in-flight beats exceed the output queue");

  // A result reaching the queue always finds a free entry.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue full on push");

  // The frame's last pixel returns the position to the frame start.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    item_go && frame_end_hit |=> col_cnt == '0 && row_cnt == '0)
    else $error("position not cleared after frame end");

  // The row count never runs past the drain row.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_cnt} <= (ROW_W + 1)'(eff_h) + (ROW_W + 1)'(1))
    else $error("row counter past the drain row");

endmodule
